/* rtl/core/rvdec_pkg.sv */
// Shared types, codes and helpers for the RV32I instruction decoder.
// No dependencies.
package rvdec_pkg;

	typedef enum logic [6:0] {
		OPC_LOAD   = 7'h03,
		OPC_FENCE  = 7'h0F,
		OPC_OPIMM  = 7'h13,
		OPC_AUIPC  = 7'h17,
		OPC_STORE  = 7'h23,
		OPC_OP     = 7'h33,
		OPC_LUI    = 7'h37,
		OPC_BRANCH = 7'h63,
		OPC_JALR   = 7'h67,
		OPC_JAL    = 7'h6F,
		OPC_SYSTEM = 7'h73
	} opcode_t;

	typedef enum logic [3:0] {
		CLS_INVALID = 4'd0,
		CLS_LOAD    = 4'd1,
		CLS_STORE   = 4'd2,
		CLS_BRANCH  = 4'd3,
		CLS_JALR    = 4'd4,
		CLS_JAL     = 4'd5,
		CLS_OPIMM   = 4'd6,
		CLS_OP      = 4'd7,
		CLS_LUI     = 4'd8,
		CLS_AUIPC   = 4'd9,
		CLS_SYSTEM  = 4'd10,
		CLS_FENCE   = 4'd11
	} op_class_t;

	typedef enum logic [2:0] {
		FMT_NONE = 3'd0,
		FMT_R    = 3'd1,
		FMT_I    = 3'd2,
		FMT_S    = 3'd3,
		FMT_B    = 3'd4,
		FMT_U    = 3'd5,
		FMT_J    = 3'd6
	} instr_format_t;

	typedef enum logic [3:0] {
		ALU_ADD   = 4'd0,
		ALU_SUB   = 4'd1,
		ALU_SLL   = 4'd2,
		ALU_SLT   = 4'd3,
		ALU_SLTU  = 4'd4,
		ALU_XOR   = 4'd5,
		ALU_SRL   = 4'd6,
		ALU_SRA   = 4'd7,
		ALU_OR    = 4'd8,
		ALU_AND   = 4'd9,
		ALU_PASSB = 4'd10
	} alu_op_t;

	typedef enum logic [1:0] {
		SIZE_NONE = 2'd0,
		SIZE_BYTE = 2'd1,
		SIZE_HALF = 2'd2,
		SIZE_WORD = 2'd3
	} access_size_t;

	// control flag bit positions
	localparam int unsigned FLAG_W       = 12;
	localparam int unsigned FL_REGWRITE  = 0;
	localparam int unsigned FL_MEMREAD   = 1;
	localparam int unsigned FL_MEMWRITE  = 2;
	localparam int unsigned FL_MEMTOREG  = 3;
	localparam int unsigned FL_ALUSRC    = 4;
	localparam int unsigned FL_BRANCH    = 5;
	localparam int unsigned FL_JUMP      = 6;
	localparam int unsigned FL_JALR      = 7;
	localparam int unsigned FL_LUI       = 8;
	localparam int unsigned FL_AUIPC     = 9;
	localparam int unsigned FL_ECALL     = 10;
	localparam int unsigned FL_MEMSIGNED = 11;

	localparam logic [6:0] FUNCT7_ALT = 7'h20;

	typedef struct packed {
		logic          is_valid;
		op_class_t     op_class;
		instr_format_t instr_format;
		logic [4:0]    dest_reg;
		logic [4:0]    src_reg_a;
		logic [4:0]    src_reg_b;
		logic [2:0]    minor_op;
		logic [6:0]    major_variant;
		logic [31:0]   immediate;
		alu_op_t       alu_operation;
		access_size_t  access_size;
		logic [FLAG_W-1:0] control_flags;
	} dec_result_t;

	function automatic logic [31:0] imm_i(input logic [31:0] w);
		return {{20{w[31]}}, w[31:20]};
	endfunction

	function automatic logic [31:0] imm_s(input logic [31:0] w);
		return {{20{w[31]}}, w[31:25], w[11:7]};
	endfunction

	function automatic logic [31:0] imm_b(input logic [31:0] w);
		return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
	endfunction

	function automatic logic [31:0] imm_u(input logic [31:0] w);
		return {w[31:12], 12'h000};
	endfunction

	function automatic logic [31:0] imm_j(input logic [31:0] w);
		return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
	endfunction

endpackage

/* rtl/core/rv32i_instruction_decoder.sv */
// Top level of the RV32I instruction decoder: input register, decode, result register.
// Depends on rvdec_pkg and rvdec_logic.
//
// Usage:
//  - Input channel: instruction_word with valid/ready. A request is taken on
//    a rising edge with valid and ready both high.
//  - Output channel: the decoded fields (is_valid ... control_flags) with
//    out_valid/out_ready, same handshake.
//  - Two register stages: the accepted word sits in the _s1 register, is
//    decoded combinationally, and the result is held in the _s2 register.
//    out_valid rises once the result is loaded into _s2, which happens as
//    soon as that stage can advance.
//  - Throughput: one request per cycle without back-pressure. The decode
//    stage is a single short cone of opcode/funct3 compares and immediate muxing.
//  - Stall: each stage advances whenever its downstream slot is empty or
//    being emptied, so a full pipeline with out_ready low holds two requests
//    and drops in_ready; nothing is lost or repeated. in_ready depends on
//    out_ready combinationally through the stage enables.
//  - Reset (arst_n low, asynchronous): both stage valid bits clear; the
//    payload registers are not reset. No state besides the pipeline.
module rv32i_instruction_decoder import rvdec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instruction_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_valid,
	output logic [3:0]  op_class,
	output logic [2:0]  instr_format,
	output logic [4:0]  dest_reg,
	output logic [4:0]  src_reg_a,
	output logic [4:0]  src_reg_b,
	output logic [2:0]  minor_op,
	output logic [6:0]  major_variant,
	output logic signed [31:0] immediate,
	output logic [3:0]  alu_operation,
	output logic [1:0]  access_size,
	output logic [11:0] control_flags
);

	logic        valid_s1;
	logic [31:0] instr_s1;
	logic        valid_s2;
	dec_result_t res_s2;
	dec_result_t dec_res;
	logic        adv_s2;
	logic        adv_s1;

	// stage 2 can load when empty or its content is leaving
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	rvdec_logic u_dec (
		.instr (instr_s1),
		.res   (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			instr_s1 <= instruction_word;
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= dec_res;
		end
	end

	assign out_valid     = valid_s2;
	assign is_valid      = res_s2.is_valid;
	assign op_class      = res_s2.op_class;
	assign instr_format  = res_s2.instr_format;
	assign dest_reg      = res_s2.dest_reg;
	assign src_reg_a     = res_s2.src_reg_a;
	assign src_reg_b     = res_s2.src_reg_b;
	assign minor_op      = res_s2.minor_op;
	assign major_variant = res_s2.major_variant;
	assign immediate     = res_s2.immediate;
	assign alu_operation = res_s2.alu_operation;
	assign access_size   = res_s2.access_size;
	assign control_flags = res_s2.control_flags;

endmodule

/* rtl/core/rvdec_logic.sv */
// Combinational decode of one RV32I instruction word into fields and control.
// Depends on rvdec_pkg.
module rvdec_logic import rvdec_pkg::*; (
	input  logic [31:0]  instr,
	output dec_result_t  res
);

	logic [6:0] opc;
	logic [2:0] f3;
	logic [6:0] f7;
	logic       alt;

	assign opc = instr[6:0];
	assign f3  = instr[14:12];
	assign f7  = instr[31:25];
	assign alt = (f7 == FUNCT7_ALT);

	always_comb begin
		res               = '0;
		res.is_valid      = 1'b1;
		res.op_class      = CLS_INVALID;
		res.instr_format  = FMT_NONE;
		res.alu_operation = ALU_ADD;
		res.access_size   = SIZE_NONE;
		// raw slices regardless of class
		res.dest_reg      = instr[11:7];
		res.src_reg_a     = instr[19:15];
		res.src_reg_b     = instr[24:20];
		res.minor_op      = f3;
		res.major_variant = f7;

		unique case (opc)
			OPC_LOAD: begin
				res.op_class     = CLS_LOAD;
				res.instr_format = FMT_I;
				res.immediate    = imm_i(instr);
				res.control_flags[FL_REGWRITE] = 1'b1;
				res.control_flags[FL_MEMREAD]  = 1'b1;
				res.control_flags[FL_MEMTOREG] = 1'b1;
				res.control_flags[FL_ALUSRC]   = 1'b1;
				case (f3)
					3'd0: begin
						res.access_size = SIZE_BYTE;
						res.control_flags[FL_MEMSIGNED] = 1'b1;
					end
					3'd1: begin
						res.access_size = SIZE_HALF;
						res.control_flags[FL_MEMSIGNED] = 1'b1;
					end
					3'd2: begin
						res.access_size = SIZE_WORD;
						res.control_flags[FL_MEMSIGNED] = 1'b1;
					end
					3'd4:    res.access_size = SIZE_BYTE;
					3'd5:    res.access_size = SIZE_HALF;
					default: res.access_size = SIZE_NONE;
				endcase
			end
			OPC_STORE: begin
				res.op_class     = CLS_STORE;
				res.instr_format = FMT_S;
				res.immediate    = imm_s(instr);
				res.control_flags[FL_MEMWRITE] = 1'b1;
				res.control_flags[FL_ALUSRC]   = 1'b1;
				case (f3)
					3'd0:    res.access_size = SIZE_BYTE;
					3'd1:    res.access_size = SIZE_HALF;
					3'd2:    res.access_size = SIZE_WORD;
					default: res.access_size = SIZE_NONE;
				endcase
			end
			OPC_BRANCH: begin
				res.op_class     = CLS_BRANCH;
				res.instr_format = FMT_B;
				res.immediate    = imm_b(instr);
				res.control_flags[FL_BRANCH] = 1'b1;
				case (f3) inside
					3'd4, 3'd5: res.alu_operation = ALU_SLT;
					3'd6, 3'd7: res.alu_operation = ALU_SLTU;
					default:    res.alu_operation = ALU_SUB;
				endcase
			end
			OPC_JALR: begin
				res.op_class     = CLS_JALR;
				res.instr_format = FMT_I;
				res.immediate    = imm_i(instr);
				res.control_flags[FL_REGWRITE] = 1'b1;
				res.control_flags[FL_JALR]     = 1'b1;
				res.control_flags[FL_ALUSRC]   = 1'b1;
			end
			OPC_JAL: begin
				res.op_class     = CLS_JAL;
				res.instr_format = FMT_J;
				res.immediate    = imm_j(instr);
				res.control_flags[FL_REGWRITE] = 1'b1;
				res.control_flags[FL_JUMP]     = 1'b1;
			end
			OPC_OPIMM, OPC_OP: begin
				res.control_flags[FL_REGWRITE] = 1'b1;
				if (opc == OPC_OPIMM) begin
					res.op_class     = CLS_OPIMM;
					res.instr_format = FMT_I;
					res.immediate    = imm_i(instr);
					res.control_flags[FL_ALUSRC] = 1'b1;
				end else begin
					res.op_class     = CLS_OP;
					res.instr_format = FMT_R;
				end
				unique case (f3)
					// subtract only exists in the register form
					3'd0: res.alu_operation = (alt && opc == OPC_OP) ? ALU_SUB : ALU_ADD;
					3'd1: res.alu_operation = ALU_SLL;
					3'd2: res.alu_operation = ALU_SLT;
					3'd3: res.alu_operation = ALU_SLTU;
					3'd4: res.alu_operation = ALU_XOR;
					3'd5: res.alu_operation = alt ? ALU_SRA : ALU_SRL;
					3'd6: res.alu_operation = ALU_OR;
					default: res.alu_operation = ALU_AND;
				endcase
			end
			OPC_LUI: begin
				res.op_class      = CLS_LUI;
				res.instr_format  = FMT_U;
				res.immediate     = imm_u(instr);
				res.alu_operation = ALU_PASSB;
				res.control_flags[FL_REGWRITE] = 1'b1;
				res.control_flags[FL_LUI]      = 1'b1;
			end
			OPC_AUIPC: begin
				res.op_class     = CLS_AUIPC;
				res.instr_format = FMT_U;
				res.immediate    = imm_u(instr);
				res.control_flags[FL_REGWRITE] = 1'b1;
				res.control_flags[FL_AUIPC]    = 1'b1;
			end
			OPC_SYSTEM: begin
				res.op_class     = CLS_SYSTEM;
				res.instr_format = FMT_I;
				res.immediate    = imm_i(instr);
				res.control_flags[FL_ECALL] = (instr[31:20] == 12'h000);
			end
			OPC_FENCE: begin
				// no-op: I format but no immediate and no control
				res.op_class     = CLS_FENCE;
				res.instr_format = FMT_I;
			end
			default: begin
				res.is_valid = 1'b0;
			end
		endcase
	end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the RV32I instruction decoder (rv32i_instruction_decoder).
// Depends on rvdec_pkg for opcodes, codes and the decoded result layout; needs the RTL only.
// Predicts every decode in the testbench, checks in order, varies idling and back-pressure.
module tb;
	import rvdec_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 10;
	localparam int PIPE_LATENCY   = 2;
	localparam int DRAIN_LIMIT    = 4000;
	localparam int TIMEOUT_CYCLES = 2_000_000;
	localparam int MAX_REPORTS    = 40;

	// one outstanding request: the word sent and the decode it must produce
	typedef struct packed {
		logic [31:0] word;
		dec_result_t result;
	} pending_decode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] instruction_word;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        is_valid;
	logic [3:0]  op_class;
	logic [2:0]  instr_format;
	logic [4:0]  dest_reg;
	logic [4:0]  src_reg_a;
	logic [4:0]  src_reg_b;
	logic [2:0]  minor_op;
	logic [6:0]  major_variant;
	logic signed [31:0] immediate;
	logic [3:0]  alu_operation;
	logic [1:0]  access_size;
	logic [11:0] control_flags;

	// decodes awaited from the block, oldest first
	pending_decode_t pending_decodes[$];
	pending_decode_t head;

	int n_sent;
	int n_checked;
	int n_errors;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;

	// the eleven recognised major opcodes, used to bias random words
	logic [6:0] opcode_list [11] = '{OPC_LOAD, OPC_FENCE, OPC_OPIMM, OPC_AUIPC, OPC_STORE,
		OPC_OP, OPC_LUI, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM};

	rv32i_instruction_decoder u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.instruction_word (instruction_word),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.is_valid         (is_valid),
		.op_class         (op_class),
		.instr_format     (instr_format),
		.dest_reg         (dest_reg),
		.src_reg_a        (src_reg_a),
		.src_reg_b        (src_reg_b),
		.minor_op         (minor_op),
		.major_variant    (major_variant),
		.immediate        (immediate),
		.alu_operation    (alu_operation),
		.access_size      (access_size),
		.control_flags    (control_flags)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predicted decode of one word. Register and funct fields are always the raw
	// slices; everything else defaults to invalid / add / no access / no flags.
	function automatic dec_result_t predict_decode(input logic [31:0] w);
		dec_result_t r;
		logic [FLAG_W-1:0] fl;
		r = '0;
		fl = '0;
		r.is_valid      = 1'b1;
		r.dest_reg      = w[11:7];
		r.src_reg_a     = w[19:15];
		r.src_reg_b     = w[24:20];
		r.minor_op      = w[14:12];
		r.major_variant = w[31:25];
		r.alu_operation = ALU_ADD;
		r.access_size   = SIZE_NONE;
		case (w[6:0])
			OPC_LOAD: begin
				r.op_class     = CLS_LOAD;
				r.instr_format = FMT_I;
				r.immediate    = 32'($signed(w[31:20]));
				fl[FL_REGWRITE] = 1'b1;
				fl[FL_MEMREAD]  = 1'b1;
				fl[FL_MEMTOREG] = 1'b1;
				fl[FL_ALUSRC]   = 1'b1;
				// funct3 3, 6, 7: load flags but no size and unsigned
				case (w[14:12])
					3'd0: begin
						r.access_size = SIZE_BYTE;
						fl[FL_MEMSIGNED] = 1'b1;
					end
					3'd1: begin
						r.access_size = SIZE_HALF;
						fl[FL_MEMSIGNED] = 1'b1;
					end
					3'd2: begin
						r.access_size = SIZE_WORD;
						fl[FL_MEMSIGNED] = 1'b1;
					end
					3'd4: r.access_size = SIZE_BYTE;
					3'd5: r.access_size = SIZE_HALF;
					default: r.access_size = SIZE_NONE;
				endcase
			end
			OPC_STORE: begin
				r.op_class     = CLS_STORE;
				r.instr_format = FMT_S;
				r.immediate    = 32'($signed({w[31:25], w[11:7]}));
				fl[FL_MEMWRITE] = 1'b1;
				fl[FL_ALUSRC]   = 1'b1;
				case (w[14:12])
					3'd0: r.access_size = SIZE_BYTE;
					3'd1: r.access_size = SIZE_HALF;
					3'd2: r.access_size = SIZE_WORD;
					default: r.access_size = SIZE_NONE;
				endcase
			end
			OPC_BRANCH: begin
				r.op_class     = CLS_BRANCH;
				r.instr_format = FMT_B;
				r.immediate    = 32'($signed({w[31], w[7], w[30:25], w[11:8], 1'b0}));
				fl[FL_BRANCH] = 1'b1;
				case (w[14:12])
					3'd4, 3'd5: r.alu_operation = ALU_SLT;
					3'd6, 3'd7: r.alu_operation = ALU_SLTU;
					default:    r.alu_operation = ALU_SUB;
				endcase
			end
			OPC_JALR: begin
				r.op_class     = CLS_JALR;
				r.instr_format = FMT_I;
				r.immediate    = 32'($signed(w[31:20]));
				fl[FL_REGWRITE] = 1'b1;
				fl[FL_JALR]     = 1'b1;
				fl[FL_ALUSRC]   = 1'b1;
			end
			OPC_JAL: begin
				r.op_class     = CLS_JAL;
				r.instr_format = FMT_J;
				r.immediate    = 32'($signed({w[31], w[19:12], w[20], w[30:21], 1'b0}));
				fl[FL_REGWRITE] = 1'b1;
				fl[FL_JUMP]     = 1'b1;
			end
			OPC_OPIMM, OPC_OP: begin
				fl[FL_REGWRITE] = 1'b1;
				if (w[6:0] == OPC_OPIMM) begin
					r.op_class     = CLS_OPIMM;
					r.instr_format = FMT_I;
					r.immediate    = 32'($signed(w[31:20]));
					fl[FL_ALUSRC]  = 1'b1;
				end else begin
					r.op_class     = CLS_OP;
					r.instr_format = FMT_R;
				end
				case (w[14:12])
					// only the register form subtracts
					3'd0: r.alu_operation = (w[6:0] == OPC_OP && w[31:25] == FUNCT7_ALT) ?
						ALU_SUB : ALU_ADD;
					3'd1: r.alu_operation = ALU_SLL;
					3'd2: r.alu_operation = ALU_SLT;
					3'd3: r.alu_operation = ALU_SLTU;
					3'd4: r.alu_operation = ALU_XOR;
					3'd5: r.alu_operation = (w[31:25] == FUNCT7_ALT) ? ALU_SRA : ALU_SRL;
					3'd6: r.alu_operation = ALU_OR;
					default: r.alu_operation = ALU_AND;
				endcase
			end
			OPC_LUI: begin
				r.op_class      = CLS_LUI;
				r.instr_format  = FMT_U;
				r.immediate     = {w[31:12], 12'd0};
				r.alu_operation = ALU_PASSB;
				fl[FL_REGWRITE] = 1'b1;
				fl[FL_LUI]      = 1'b1;
			end
			OPC_AUIPC: begin
				r.op_class     = CLS_AUIPC;
				r.instr_format = FMT_U;
				r.immediate    = {w[31:12], 12'd0};
				fl[FL_REGWRITE] = 1'b1;
				fl[FL_AUIPC]    = 1'b1;
			end
			OPC_SYSTEM: begin
				r.op_class     = CLS_SYSTEM;
				r.instr_format = FMT_I;
				r.immediate    = 32'($signed(w[31:20]));
				// ecall only with funct12 all zero
				fl[FL_ECALL] = (w[31:20] == 12'd0);
			end
			OPC_FENCE: begin
				r.op_class     = CLS_FENCE;
				r.instr_format = FMT_I;
			end
			default: begin
				r.is_valid     = 1'b0;
				r.op_class     = CLS_INVALID;
				r.instr_format = FMT_NONE;
			end
		endcase
		r.control_flags = fl;
		return r;
	endfunction

	// Mostly well-formed words with random content; the rest is raw noise.
	function automatic logic [31:0] random_instruction();
		logic [31:0] w;
		w = $urandom();
		if ($urandom_range(99) < 85) begin
			w[6:0] = opcode_list[$urandom_range(10)];
			// steer funct7 onto the alternate/base encodings often
			if ($urandom_range(2) == 0)
				w[31:25] = $urandom_range(1) ? FUNCT7_ALT : 7'h00;
			if (w[6:0] == OPC_SYSTEM && $urandom_range(2) == 0)
				w[31:20] = 12'd0;
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] word,
			input logic [31:0] got, input logic [31:0] want);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("[%0t] MISMATCH %s: word %08h got %08h want %08h",
				$realtime, what, word, got, want);
	endtask

	// Offer one request. Entered and left at a falling edge; valid stays high on
	// return so that back-to-back requests never drop it within one step.
	task automatic send_request(input logic [31:0] word);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid         <= 1'b1;
		instruction_word <= word;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			if (in_ready) begin
				taken = 1'b1;
				pending_decodes.push_back('{word: word, result: predict_decode(word)});
				n_sent++;
			end
			@(negedge clk);
		end
	endtask

	// Sender pauses until every awaited decode is back, then lets the pipe settle.
	task automatic wait_results_drained();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (pending_decodes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (pending_decodes.size() != 0) begin
			report_mismatch("result never arrived", pending_decodes[0].word, 32'd0, 32'd1);
			pending_decodes.delete();
		end
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	// Field extremes, every opcode group and each corner of the decode tables.
	task automatic test_directed_cases();
		send_idle_pct = 16;
		recv_idle_pct = 68;
		send_request(32'h0000_0000);                                  // opcode 0, unknown
		send_request(32'hFFFF_FFFF);                                  // all ones, unknown
		send_request({12'hFFF, 5'd31, 3'd0, 5'd31, OPC_LOAD});        // lb, imm -1
		send_request({12'h7FF, 5'd0, 3'd3, 5'd1, OPC_LOAD});          // no size, funct3 3
		send_request({12'h800, 5'd5, 3'd6, 5'd2, OPC_LOAD});          // no size, funct3 6
		send_request({12'h001, 5'd9, 3'd7, 5'd3, OPC_LOAD});          // no size, funct3 7
		send_request({12'h7FF, 5'd17, 3'd4, 5'd0, OPC_LOAD});         // lbu
		send_request({12'h123, 5'd1, 3'd5, 5'd4, OPC_LOAD});          // lhu
		send_request({7'h40, 5'd31, 5'd31, 3'd2, 5'd0, OPC_STORE});   // sw, most negative
		send_request({7'h3F, 5'd2, 5'd3, 3'd5, 5'd31, OPC_STORE});    // store funct3 above 2
		send_request({7'h7F, 5'd31, 5'd31, 3'd2, 5'd31, OPC_BRANCH}); // funct3 2: sub
		send_request({7'h00, 5'd1, 5'd2, 3'd3, 5'd1, OPC_BRANCH});    // funct3 3: sub
		send_request({7'h3F, 5'd4, 5'd5, 3'd5, 5'd30, OPC_BRANCH});   // bge
		send_request({7'h41, 5'd6, 5'd7, 3'd7, 5'd15, OPC_BRANCH});   // bgeu
		send_request({12'h800, 5'd1, 3'd0, 5'd1, OPC_JALR});
		send_request({20'hFFFFF, 5'd31, OPC_JAL});
		send_request({20'h7FFFF, 5'd0, OPC_JAL});
		send_request({FUNCT7_ALT, 5'd31, 5'd8, 3'd5, 5'd9, OPC_OPIMM}); // srai
		send_request({7'h01, 5'd3, 5'd8, 3'd5, 5'd9, OPC_OPIMM});       // srli, odd funct7
		send_request({FUNCT7_ALT, 5'd2, 5'd1, 3'd0, 5'd3, OPC_OP});     // sub
		send_request({7'h01, 5'd2, 5'd1, 3'd0, 5'd3, OPC_OP});          // add, odd funct7
		send_request({7'h7F, 5'd2, 5'd1, 3'd5, 5'd3, OPC_OP});          // srl, odd funct7
		send_request({20'hFFFFF, 5'd7, OPC_LUI});
		send_request({20'h80000, 5'd8, OPC_AUIPC});
		send_request({25'd0, OPC_SYSTEM});                              // ecall
		send_request({12'h001, 13'd0, OPC_SYSTEM});                     // ebreak, no ecall
		send_request(32'h0FF0_000F);                                    // fence
		wait_results_drained();
	endtask

	// Random traffic under one idling mix.
	task automatic test_random_decode(input int count, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) send_request(random_instruction());
		wait_results_drained();
	endtask

	// Receiver holds off for a long stretch while requests keep coming: both
	// stages fill, in_ready falls and the sender must wait it out.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles   = 60;
		repeat (30) send_request(random_instruction());
		wait_results_drained();
	endtask

	// Receiver: random idling, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Checker: each accepted decode against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_decodes.size() == 0) begin
				report_mismatch("result with none awaited", 32'd0, {20'd0, control_flags}, 32'd0);
			end else begin
				head = pending_decodes.pop_front();
				n_checked++;
				if (is_valid !== head.result.is_valid)
					report_mismatch("is_valid", head.word, 32'(is_valid),
						32'(head.result.is_valid));
				if (op_class !== head.result.op_class)
					report_mismatch("op_class", head.word, 32'(op_class),
						32'(head.result.op_class));
				if (instr_format !== head.result.instr_format)
					report_mismatch("instr_format", head.word, 32'(instr_format),
						32'(head.result.instr_format));
				if (dest_reg !== head.result.dest_reg)
					report_mismatch("dest_reg", head.word, 32'(dest_reg),
						32'(head.result.dest_reg));
				if (src_reg_a !== head.result.src_reg_a)
					report_mismatch("src_reg_a", head.word, 32'(src_reg_a),
						32'(head.result.src_reg_a));
				if (src_reg_b !== head.result.src_reg_b)
					report_mismatch("src_reg_b", head.word, 32'(src_reg_b),
						32'(head.result.src_reg_b));
				if (minor_op !== head.result.minor_op)
					report_mismatch("minor_op", head.word, 32'(minor_op),
						32'(head.result.minor_op));
				if (major_variant !== head.result.major_variant)
					report_mismatch("major_variant", head.word, 32'(major_variant),
						32'(head.result.major_variant));
				if (immediate !== head.result.immediate)
					report_mismatch("immediate", head.word, immediate,
						head.result.immediate);
				if (alu_operation !== head.result.alu_operation)
					report_mismatch("alu_operation", head.word, 32'(alu_operation),
						32'(head.result.alu_operation));
				if (access_size !== head.result.access_size)
					report_mismatch("access_size", head.word, 32'(access_size),
						32'(head.result.access_size));
				if (control_flags !== head.result.control_flags)
					report_mismatch("control_flags", head.word, 32'(control_flags),
						32'(head.result.control_flags));
			end
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		n_sent           = 0;
		n_checked        = 0;
		n_errors         = 0;
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		hold_cycles      = 0;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		instruction_word = 32'd0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_random_decode(500, 16, 68);
		test_random_decode(500, 68, 16);
		test_output_backpressure();
		test_random_decode(500, 0, 0);

		$display("Run covered %0d requests and %0d checked decodes: directed corners,",
			n_sent, n_checked);
		$display("three idling mixes and a long output hold-off; %0d mismatches.", n_errors);
		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/rvdec_pkg.sv
rtl/core/rvdec_logic.sv
rtl/core/rv32i_instruction_decoder.sv
sim/tb.sv
